### design/chu_pkg.sv
`default_nettype none

package chu_pkg;

    localparam logic [7:0] CARET = 8'h5E;
    localparam int unsigned MAX_RES = 3;

    typedef enum logic [1:0]
    {
        PH_IDLE  = 2'd0,
        PH_CARET = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    typedef logic [1:0] res_cnt_t;

    typedef struct packed
    {
        logic [7:0] data;
        logic       last_of_item;
        logic       record_end;
    } res_t;

    typedef struct packed
    {
        res_cnt_t           cnt;
        res_t [MAX_RES-1:0] ent;
    } burst_t;

    function automatic logic hex_ok(input logic [7:0] c);
        logic r;
        begin
            r = ((c >= 8'h30) && (c <= 8'h39)) ||
                ((c >= 8'h41) && (c <= 8'h46)) ||
                ((c >= 8'h61) && (c <= 8'h66));
            return r;
        end
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] r;
        begin
            if (c <= 8'h39)
            begin
                r = c[3:0];
            end
            else
            begin
                r = c[3:0] + 4'd9;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

### design/chu_decode.sv
`default_nettype none

module chu_decode
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_end,
    output chu_pkg::burst_t    burst
);
    import chu_pkg::*;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    res_cnt_t   cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;

    // escape phase and held byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    always_comb
    begin
        phase_next = PH_IDLE;
        held_next  = held_reg;
        cnt        = 2'd0;
        b0         = in_byte;
        b1         = in_byte;
        b2         = in_byte;
        unique case (phase_reg)
            PH_CARET:
            begin
                if (in_byte == CARET)
                begin
                    cnt = 2'd1;
                    b0  = CARET;
                end
                else if (in_end)
                begin
                    cnt = 2'd2;
                    b0  = CARET;
                    b1  = in_byte;
                end
                else
                begin
                    held_next  = in_byte;
                    phase_next = PH_DIGIT;
                end
            end
            PH_DIGIT:
            begin
                if (hex_ok(held_reg) && hex_ok(in_byte))
                begin
                    cnt = 2'd1;
                    b0  = {hex_val(held_reg), hex_val(in_byte)};
                end
                else
                begin
                    cnt = 2'd3;
                    b0  = CARET;
                    b1  = held_reg;
                    b2  = in_byte;
                end
            end
            default:
            begin
                if ((in_byte == CARET) && !in_end)
                begin
                    phase_next = PH_CARET;
                end
                else
                begin
                    cnt = 2'd1;
                    b0  = in_byte;
                end
            end
        endcase
    end

    always_comb
    begin
        burst.cnt         = cnt;
        burst.ent[0].data = b0;
        burst.ent[1].data = b1;
        burst.ent[2].data = b2;
        for (int i = 0; i < MAX_RES; i++)
        begin
            burst.ent[i].last_of_item = (cnt == res_cnt_t'(i + 1));
            burst.ent[i].record_end   = (cnt == res_cnt_t'(i + 1)) && in_end;
        end
    end

endmodule

`default_nettype wire

### design/chu_burst.sv
`default_nettype none

module chu_burst
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            load,
    input  wire chu_pkg::burst_t burst,
    output logic                 free,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);
    import chu_pkg::*;

    res_cnt_t           cnt_reg;
    res_cnt_t           cnt_next;
    res_t [MAX_RES-1:0] ent_reg;
    res_t [MAX_RES-1:0] ent_next;
    logic               take;

    assign take     = (cnt_reg != 2'd0) && m_tready;
    assign free     = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = ent_reg[0].data;
    assign m_tuser  = ent_reg[0].last_of_item;
    assign m_tlast  = ent_reg[0].record_end;

    always_comb
    begin
        cnt_next = cnt_reg;
        ent_next = ent_reg;
        if (load)
        begin
            cnt_next = burst.cnt;
            ent_next = burst.ent;
        end
        else if (take)
        begin
            cnt_next   = cnt_reg - 2'd1;
            ent_next[0] = ent_reg[1];
            ent_next[1] = ent_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // pending beats, head in entry 0
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

### design/caret_hex_unescape.sv
// path: an accepted input beat is registered, then decoded and loaded into the burst buffer once it is free
// throughput: one input beat per cycle while each gives at most one result and m_tready is high;
//   a beat giving more results holds the input side until the burst buffer is sending its last one
// reset: rst_n asynchronous, active low; clears escape phase, held byte and
//   all valid flags, the block is ready to take input on release
`default_nettype none

module caret_hex_unescape
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // in_record_end
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tuser,   // out_last_of_item
    output logic            m_tlast    // out_record_end
);
    import chu_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       free;
    logic       adv;
    burst_t     burst;

    assign adv      = in_valid_reg && free;
    assign s_tready = !in_valid_reg || free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    chu_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_byte (in_byte_reg),
        .in_end  (in_end_reg),
        .burst   (burst)
    );

    chu_burst u_burst
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv),
        .burst    (burst),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### design/chu_checker.sv
`default_nettype none

module chu_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       s_tlast,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    // nothing offered while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result beat during reset");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat withdrawn");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result beat changed");

    // record end only on the final result of an input beat
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("record end without last of item");

    // after a record-end input is taken, a record-end result offered must also carry last of item
    a_end_flush: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !m_tvalid || !m_tlast || m_tuser)
        else $error("record end flag malformed");

endmodule

bind caret_hex_unescape chu_checker u_chk (.*);

`default_nettype wire
